FILE: rtl/cbs_pkg.sv
// Shared types and codes for the cell bitmap set with find-first.
// Used by cell_bitmap_set_find_first and the testbench; no dependencies.
package cbs_pkg;

    // Default sizing of the set
    localparam int NUM_CELLS_DEF = 256;
    localparam int WORD_BITS_DEF = 8;

    // Request action codes
    localparam logic [2:0] ACT_CLEAR    = 3'd0;
    localparam logic [2:0] ACT_ADD      = 3'd1;
    localparam logic [2:0] ACT_REMOVE   = 3'd2;
    localparam logic [2:0] ACT_FIND     = 3'd3;
    localparam logic [2:0] ACT_IS_EMPTY = 3'd4;
    localparam logic [2:0] ACT_TAKE     = 3'd5;

    // Request transaction payload
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] cell_number;
    } req_t;

    // Result transaction payload
    typedef struct packed {
        logic       member;
        logic       set_empty;
        logic [7:0] lowest_cell;
        logic       range_error;
    } rsp_t;

endpackage

FILE: rtl/cbs_word_store.sv
// Bitmap word memory with a per-word nonzero flag used as occupancy summary.
// Depends on nothing outside this file; instantiated by the top level.
module cbs_word_store #(
    parameter int WORD_COUNT = 32,
    parameter int WORD_BITS  = 8,
    parameter int IDX_W      = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [WORD_BITS-1:0]  rd_word,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [WORD_BITS-1:0]  wr_word,
    input  logic                  clr,
    output logic [WORD_COUNT-1:0] nonzero
);

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_BITS-1:0]  rdata_reg;
    logic                  rflag_reg;
    logic [WORD_COUNT-1:0] nonzero_reg;
    logic [WORD_COUNT-1:0] nonzero_next;

    // Synchronous memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    // Flag update: a word whose flag is low reads as zero, so clear only drops flags
    always_comb
    begin
        nonzero_next = nonzero_reg;
        if (clr)
        begin
            nonzero_next = '0;
        end
        else if (wr_en)
        begin
            nonzero_next[wr_idx] = (wr_word != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonzero_reg <= '0;
            rflag_reg   <= 1'b0;
        end
        else
        begin
            nonzero_reg <= nonzero_next;
            if (rd_en)
            begin
                rflag_reg <= nonzero_reg[rd_idx];
            end
        end
    end

    assign rd_word = rflag_reg ? rdata_reg : '0;
    assign nonzero = nonzero_reg;

endmodule

FILE: rtl/cell_bitmap_set_find_first.sv
// Cell set bitmap with find-first-set, top level.
// Depends on cbs_pkg and cbs_word_store.
//
// Usage:
//   A request transaction (req: action, cell_number) is taken at a rising
//   edge where start is high and busy is low. Exactly one result transaction
//   follows on rsp, marked by done for a single cycle; the receiver cannot
//   hold it off.
//   The request is captured at the accepting edge and worked in the ACCESS
//   state; rsp and done are registered as ACCESS ends. busy is high for one
//   cycle after the accept, so a new request can be taken while done is high.
//   Requests are spaced by the word memory's registered read followed by the
//   modify and write-back of the same word; a per-word nonzero flag register
//   picks the word for take-lowest and answers is-empty without a scan.
//   Each access reads at the accepting edge and writes at the next, so two
//   requests never overlap on the same word.
//   Reset: the set is empty (all nonzero flags cleared), no request pending,
//   done low. Clear drops every flag at once; no memory sweep is run.
module cell_bitmap_set_find_first #(
    parameter int NUM_CELLS = cbs_pkg::NUM_CELLS_DEF,
    parameter int WORD_BITS = cbs_pkg::WORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cbs_pkg::req_t req,
    output logic          done,
    output cbs_pkg::rsp_t rsp
);

    import cbs_pkg::*;

    localparam int WORD_COUNT = (NUM_CELLS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BPOS_W     = $clog2(WORD_BITS);
    localparam int LOW_W      = IDX_W + BPOS_W + 1;
    localparam int RECIP      = (65536 + WORD_BITS - 1) / WORD_BITS;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_ACCESS = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic                  accept;

    logic [2:0]            act_reg;
    logic                  in_range_reg;
    logic                  empty_reg;
    logic [IDX_W-1:0]      widx_reg;
    logic [BPOS_W-1:0]     bpos_reg;
    logic                  done_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic [24:0]           prod;
    logic [7:0]            quot;
    logic [13:0]           quot_bits;
    logic [7:0]            rem;
    logic                  in_range;
    logic [IDX_W-1:0]      cell_idx;
    logic [IDX_W-1:0]      first_idx;
    logic [IDX_W-1:0]      rd_idx;

    logic [WORD_BITS-1:0]  rd_word;
    logic [WORD_COUNT-1:0] nonzero;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  wr_word;
    logic                  clr;
    logic [BPOS_W-1:0]     low_bit;
    logic [WORD_BITS-1:0]  bit_mask;
    logic [WORD_BITS-1:0]  low_mask;
    logic [LOW_W-1:0]      low_cell;

    assign busy   = (state_reg == ST_ACCESS);
    assign accept = start && !busy;

    // Split cell number into word index and bit position (reciprocal multiply)
    assign prod      = 25'(req.cell_number) * 25'(RECIP);
    assign quot      = prod[23:16];
    assign quot_bits = 14'(quot) * 14'(WORD_BITS);
    assign rem       = req.cell_number - quot_bits[7:0];
    assign cell_idx  = IDX_W'(quot);
    assign in_range  = 32'(req.cell_number) < 32'(NUM_CELLS);

    // Lowest occupied word from the nonzero flags
    always_comb
    begin
        first_idx = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--)
        begin
            if (nonzero[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign rd_idx = (req.action == ACT_TAKE) ? first_idx : cell_idx;

    // Lowest set bit of the word read back
    always_comb
    begin
        low_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (rd_word[b])
            begin
                low_bit = BPOS_W'(b);
            end
        end
    end

    assign bit_mask = WORD_BITS'(1) << bpos_reg;
    assign low_mask = WORD_BITS'(1) << low_bit;
    assign low_cell = (LOW_W'(widx_reg) * LOW_W'(WORD_BITS)) + LOW_W'(low_bit);

    // Word store
    cbs_word_store #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (rd_idx),
        .rd_word (rd_word),
        .wr_en   (wr_en),
        .wr_idx  (widx_reg),
        .wr_word (wr_word),
        .clr     (clr),
        .nonzero (nonzero)
    );

    // Modify and write back, build the result
    always_comb
    begin
        rsp_next = '0;
        wr_en    = 1'b0;
        wr_word  = rd_word;
        clr      = 1'b0;
        if (state_reg == ST_ACCESS)
        begin
            case (act_reg)
                ACT_CLEAR:
                begin
                    clr = 1'b1;
                end
                ACT_ADD:
                begin
                    if (in_range_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_word = rd_word | bit_mask;
                    end
                    else
                    begin
                        rsp_next.range_error = 1'b1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (in_range_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_word = rd_word & ~bit_mask;
                    end
                    else
                    begin
                        rsp_next.range_error = 1'b1;
                    end
                end
                ACT_FIND:
                begin
                    if (in_range_reg)
                    begin
                        rsp_next.member = rd_word[bpos_reg];
                    end
                    else
                    begin
                        rsp_next.range_error = 1'b1;
                    end
                end
                ACT_IS_EMPTY:
                begin
                    rsp_next.set_empty = empty_reg;
                end
                ACT_TAKE:
                begin
                    if (empty_reg)
                    begin
                        rsp_next.set_empty = 1'b1;
                    end
                    else
                    begin
                        wr_en                = 1'b1;
                        wr_word              = rd_word & ~low_mask;
                        rsp_next.lowest_cell = low_cell[7:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: IDLE takes a request, ACCESS finishes it
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_ACCESS : ST_IDLE;
            ST_ACCESS: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_ACCESS);
        end
    end

    // Request capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= req.action;
            in_range_reg <= in_range;
            empty_reg    <= (nonzero == '0);
            widx_reg     <= rd_idx;
            bpos_reg     <= BPOS_W'(rem);
        end
        if (state_reg == ST_ACCESS)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // An accepted request is followed by busy and then by done
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 done)
        else $error("request did not complete in two cycles");

    // A result is only given when busy was high before it
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a pending request");

    // Clearing leaves every word flagged empty
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clr |=> (nonzero == '0))
        else $error("occupancy flags not cleared");

    // An out-of-range request never reports membership
    a_range_no_member: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.range_error) |-> !rsp.member)
        else $error("member reported with range error");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for cell_bitmap_set_find_first (start/busy/done command port).
// Depends on cbs_pkg and the cell_bitmap_set_find_first RTL; it reads no files.
`timescale 1ns / 100ps

module tb;
    import cbs_pkg::*;

    localparam int NUM_CELLS   = NUM_CELLS_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RAND_ITEMS  = 530;
    localparam int MAX_REPORTS = 10;

    // Spare action codes: the block must ignore them
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct {
        req_t request;
        bit   typed;
        rsp_t typed_rsp;
    } dir_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    // Typed expectation travels with the request it belongs to
    logic  req_typed;
    rsp_t  req_typed_rsp;

    logic [NUM_CELLS-1:0] cell_set_mirror;
    rsp_t                 pending_rsp[$];
    dir_row_t             dir_rows[$];
    int                   mismatch_count;
    int                   cycle_count;
    bit                   idle_on;

    cell_bitmap_set_find_first u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Cycle limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Predict one request against the mirrored set; updates the mirror
    function automatic rsp_t apply_set_request(input req_t r);
        rsp_t res;
        bit   hit;
        res = '0;
        hit = 1'b0;
        case (r.action)
            ACT_CLEAR:
                cell_set_mirror = '0;
            ACT_ADD:
                if (int'(r.cell_number) < NUM_CELLS)
                    cell_set_mirror[r.cell_number] = 1'b1;
                else
                    res.range_error = 1'b1;
            ACT_REMOVE:
                if (int'(r.cell_number) < NUM_CELLS)
                    cell_set_mirror[r.cell_number] = 1'b0;
                else
                    res.range_error = 1'b1;
            ACT_FIND:
                if (int'(r.cell_number) < NUM_CELLS)
                    res.member = cell_set_mirror[r.cell_number];
                else
                    res.range_error = 1'b1;
            ACT_IS_EMPTY:
                res.set_empty = (cell_set_mirror == '0);
            ACT_TAKE:
            begin
                for (int i = 0; i < NUM_CELLS; i++)
                begin
                    if (!hit && cell_set_mirror[i])
                    begin
                        hit = 1'b1;
                        cell_set_mirror[i] = 1'b0;
                        res.lowest_cell = 8'(i);
                    end
                end
                if (!hit)
                    res.set_empty = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Scoreboard: check a finished result, then record the newly accepted request.
    // The check comes first since a result and an accept can share one edge.
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t pred;
        if (done === 1'b1)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] result with nothing pending: %p", $realtime, rsp);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.member !== want.member || rsp.set_empty !== want.set_empty ||
                    rsp.lowest_cell !== want.lowest_cell ||
                    rsp.range_error !== want.range_error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] mismatch: exp mem=%0b emp=%0b low=%0d rerr=%0b,",
                                 $realtime, want.member, want.set_empty, want.lowest_cell,
                                 want.range_error,
                                 " got mem=%0b emp=%0b low=%0d rerr=%0b",
                                 rsp.member, rsp.set_empty, rsp.lowest_cell,
                                 rsp.range_error);
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            pred = apply_set_request(req);
            pending_rsp.push_back(req_typed ? req_typed_rsp : pred);
        end
    end

    // Queue one directed row
    task automatic add_row(input logic [2:0] act, input logic [7:0] cell_num, input bit typed,
                           input logic m, input logic e, input logic [7:0] low);
        dir_row_t row;
        row.request.action      = act;
        row.request.cell_number = cell_num;
        row.typed               = typed;
        row.typed_rsp           = '{member: m, set_empty: e, lowest_cell: low,
                                    range_error: 1'b0};
        dir_rows.push_back(row);
    endtask

    // Drive one request transaction, returning at the edge that accepts it
    task automatic send_request(input req_t r, input bit typed, input rsp_t texp);
        int gap;
        if (idle_on && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        req           <= r;
        req_typed     <= typed;
        req_typed_rsp <= texp;
        start         <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // Random request: mostly adds and takes over a few hot cell ranges
    function automatic req_t random_request(input bit drain);
        req_t r;
        int   pick;
        int   span;
        pick = $urandom_range(99);
        span = $urandom_range(3);
        if (span == 0)
            r.cell_number = 8'($urandom_range(255));
        else if (span == 1)
            r.cell_number = 8'($urandom_range(255, 236));
        else
            r.cell_number = 8'($urandom_range(23));
        if (pick < (drain ? 20 : 38))
            r.action = ACT_ADD;
        else if (pick < 50)
            r.action = ACT_REMOVE;
        else if (pick < 65)
            r.action = ACT_FIND;
        else if (pick < 73)
            r.action = ACT_IS_EMPTY;
        else if (pick < 95)
            r.action = ACT_TAKE;
        else if (pick < 97)
            r.action = ACT_CLEAR;
        else
            r.action = $urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6;
        return r;
    endfunction

    // Main sequence
    initial
    begin
        int   settle;
        rsp_t none;
        none            = '0;
        mismatch_count  = 0;
        cell_set_mirror = '0;
        idle_on         = 1'b1;
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        req_typed       = 1'b0;
        req_typed_rsp   = '0;

        // Directed rows: empty set, extremes, word boundaries, spare codes, clear
        add_row(ACT_IS_EMPTY, 8'd0,   1, 1'b0, 1'b1, 8'd0);
        add_row(ACT_TAKE,     8'd0,   1, 1'b0, 1'b1, 8'd0);
        add_row(ACT_FIND,     8'd0,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_FIND,     8'd255, 1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_ADD,      8'd255, 1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_ADD,      8'd0,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_FIND,     8'd255, 1, 1'b1, 1'b0, 8'd0);
        add_row(ACT_FIND,     8'd0,   1, 1'b1, 1'b0, 8'd0);
        add_row(ACT_IS_EMPTY, 8'd0,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_TAKE,     8'd0,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_TAKE,     8'd0,   1, 1'b0, 1'b0, 8'd255);
        add_row(ACT_TAKE,     8'd0,   1, 1'b0, 1'b1, 8'd0);
        add_row(ACT_ADD,      8'd7,   0, 1'b0, 1'b0, 8'd0);
        add_row(ACT_ADD,      8'd8,   0, 1'b0, 1'b0, 8'd0);
        add_row(ACT_ADD,      8'd170, 0, 1'b0, 1'b0, 8'd0);
        add_row(ACT_ADD,      8'd85,  0, 1'b0, 1'b0, 8'd0);
        add_row(ACT_REMOVE,   8'd8,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_FIND,     8'd8,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_SPARE_6,  8'd255, 1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_SPARE_7,  8'd60,  1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_TAKE,     8'd0,   0, 1'b0, 1'b0, 8'd0);
        add_row(ACT_IS_EMPTY, 8'd0,   0, 1'b0, 1'b0, 8'd0);
        add_row(ACT_CLEAR,    8'd0,   1, 1'b0, 1'b0, 8'd0);
        add_row(ACT_IS_EMPTY, 8'd0,   1, 1'b0, 1'b1, 8'd0);
        add_row(ACT_REMOVE,   8'd128, 1, 1'b0, 1'b0, 8'd0);

        // Reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].request, dir_rows[i].typed, dir_rows[i].typed_rsp);

        // Random traffic; back-to-back stretch in the middle, drain bias late
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            idle_on = !(n >= 180 && n < 300);
            if (n == 400)
            begin
                // Hold off until every outstanding result has come back
                start <= 1'b0;
                do @(posedge clk); while (pending_rsp.size() != 0);
            end
            send_request(random_request(n >= 420), 1'b0, none);
        end
        start     <= 1'b0;
        req_typed <= 1'b0;

        // Wait for outstanding results, then settle to catch stray ones
        do @(posedge clk); while (pending_rsp.size() != 0);
        settle = 6;
        repeat (settle) @(posedge clk);

        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/cbs_pkg.sv
rtl/cbs_word_store.sv
rtl/cell_bitmap_set_find_first.sv
tb/tb.sv
